FILE: hdl/uflh_pkg.sv
// ----------------------------------------------------------------------------
// uflh_pkg
// Shared types and constants of the upload frame ledger.
// ----------------------------------------------------------------------------
package uflh_pkg;

  localparam int unsigned LightmapSlotsDefault = 2;
  localparam logic [63:0] FnvPrime = 64'd1099511628211;
  localparam logic [63:0] FnvBasis = 64'd14695981039346656037;
  localparam int unsigned HashBytes = 40;

  typedef struct packed {
    logic [31:0] frame_index;
    logic [31:0] tr_bytes;
    logic [31:0] lm_bytes;
    logic        full_upload;
    logic        variable_mode;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [32:0] frame_bytes;
    logic [47:0] transient_sum;
    logic [47:0] lightmap_sum;
    logic [47:0] upload_sum;
    logic [63:0] chain_hash;
    logic [31:0] transient_low;
    logic [31:0] transient_high;
    logic [31:0] variation_count;
    logic [32:0] frame_bytes_low;
    logic [32:0] frame_bytes_high;
    logic [31:0] frames_done;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word; rules are evaluated in CHECK
    logic hash_step; // fold one byte
    logic commit;    // write state if record is good
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic hash_last;
  } dp_stat_t;

endpackage

FILE: hdl/uflh_if.sv
// ----------------------------------------------------------------------------
// uflh_if
// Valid/ready channel carrying one word of a generic payload.
// ----------------------------------------------------------------------------
interface uflh_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/upload_frame_ledger_with_hash.sv
// ----------------------------------------------------------------------------
// upload_frame_ledger_with_hash
// Frame upload ledger with rule checks, statistics and an FNV-1a-64 hash.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      frame record (in_word_t)
//   out_ch    out  valid/ready      ledger result (out_word_t)
//   cfg       in   cfg_we           slot_image_bytes
//
// Each record goes through load, a rule-check state, 40 hash byte steps
// done by shift and add, commit and output. A rejected record skips the
// hash loop. The result register holds until taken; the next record
// waits until it is. Reset (rst, synchronous) gives the init state.
// ----------------------------------------------------------------------------
module upload_frame_ledger_with_hash #(
  parameter int unsigned LIGHTMAP_SLOTS = uflh_pkg::LightmapSlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  uflh_if.sink        in_ch,
  uflh_if.source      out_ch
);
  import uflh_pkg::*;

  logic [31:0] slot_image_bytes;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  out_word_t   res;
  logic        in_ready, out_valid;

  // hold configuration register
  always_ff @(posedge clk) begin
    if (rst) slot_image_bytes <= 32'd1;
    else if (cfg_we) slot_image_bytes <= cfg_wdata;
  end

  uflh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  uflh_dp #(.LIGHTMAP_SLOTS(LIGHTMAP_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .slot_image_bytes(slot_image_bytes),
    .in_word(in_ch.data), .cmd(cmd), .stat(stat), .out_word(res)
  );

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data = res;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_commit_then_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_ch.valid) else $error("commit without result");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.status) |-> out_ch.data.frame_bytes == 33'd0)
    else $error("rejected result carries a total");
endmodule

FILE: hdl/uflh_ctrl.sv
// ----------------------------------------------------------------------------
// uflh_ctrl
// Sequencer: load, check, hash byte loop, commit, output handoff.
// ----------------------------------------------------------------------------
module uflh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output uflh_pkg::dp_cmd_t cmd,
  input  uflh_pkg::dp_stat_t stat
);
  import uflh_pkg::*;

  typedef enum logic [1:0] {IDLE, CHECK, HASH, SEND} state_t;
  state_t state;

  assign in_ready = (state == IDLE) && !out_valid;

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.hash_step = (state == HASH);
    cmd.commit = (state == SEND);
  end

  // advance through one record; hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        IDLE: if (cmd.load) state <= CHECK;
        CHECK: state <= stat.bad ? SEND : HASH;
        HASH: if (stat.hash_last) state <= SEND;
        SEND: begin
          out_valid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/uflh_dp.sv
// ----------------------------------------------------------------------------
// uflh_dp
// Ledger state, rule checks and a byte-serial FNV-1a hash unit.
// ----------------------------------------------------------------------------
module uflh_dp #(
  parameter int unsigned LIGHTMAP_SLOTS = uflh_pkg::LightmapSlotsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         slot_image_bytes,
  input  uflh_pkg::in_word_t  in_word,
  input  uflh_pkg::dp_cmd_t   cmd,
  output uflh_pkg::dp_stat_t  stat,
  output uflh_pkg::out_word_t out_word
);
  import uflh_pkg::*;

  localparam int unsigned CntW = $clog2(HashBytes);
  localparam int unsigned QuotaShift = 32 + $clog2(LIGHTMAP_SLOTS);
  localparam logic [32:0] QuotaRecip =
    33'(((69'd1 << QuotaShift) + 69'(LIGHTMAP_SLOTS) - 69'd1) / 69'(LIGHTMAP_SLOTS));

  in_word_t    rec;
  logic [31:0] quota;
  logic [68:0] quota_prod;
  logic [32:0] ftot;
  logic [48:0] nt, nl, nu;
  logic        bad, bad_c;

  logic [31:0] frame_count, first_transient, bounded_size;
  logic [31:0] t_min, t_max, variation, full_count;
  logic [32:0] f_min, f_max;
  logic [47:0] tot_t, tot_l, tot_u;
  logic [63:0] hash_reg, hash_work;
  logic        mode_reg;
  logic [CntW-1:0] byte_cnt;
  logic [319:0] hash_src;
  logic [7:0]  hbyte;
  logic [63:0] hx;
  logic        status_q;
  logic [32:0] ftot_q;

  // divide by slot count as a multiply by the rounded-up reciprocal
  assign quota_prod = 69'(slot_image_bytes) * 69'(QuotaRecip);
  assign quota = quota_prod[QuotaShift +: 32];
  assign ftot = {1'b0, rec.tr_bytes} + {1'b0, rec.lm_bytes};

  // capture record
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec <= in_word;
    end
  end

  // candidate totals, one bit wider to catch overflow
  assign nt = {1'b0, tot_t} + {17'd0, rec.tr_bytes};
  assign nl = {1'b0, tot_l} + {17'd0, rec.lm_bytes};
  assign nu = {1'b0, tot_u} + {16'd0, ftot};

  // evaluate rules in CHECK
  always_comb begin
    logic exp_full;
    exp_full = ({32'd0, rec.frame_index} < 64'(LIGHTMAP_SLOTS));
    bad_c = 1'b0;
    if (frame_count != 32'd0 && mode_reg != rec.variable_mode) bad_c = 1'b1;
    if (rec.frame_index != frame_count) bad_c = 1'b1;
    if (rec.tr_bytes == 32'd0 || rec.lm_bytes == 32'd0) bad_c = 1'b1;
    if (rec.full_upload != exp_full) bad_c = 1'b1;
    if (rec.full_upload && rec.lm_bytes != quota) bad_c = 1'b1;
    if (!rec.full_upload && rec.lm_bytes >= quota) bad_c = 1'b1;
    if (!rec.variable_mode && first_transient != 32'd0 &&
        first_transient != rec.tr_bytes) bad_c = 1'b1;
    if (bounded_size != 32'd0 && !rec.full_upload &&
        bounded_size != rec.lm_bytes) bad_c = 1'b1;
    if (nt[48] || nl[48] || nu[48]) bad_c = 1'b1;
    if (frame_count == 32'hFFFF_FFFF) bad_c = 1'b1;
    if (rec.full_upload && full_count == 32'hFFFF_FFFF) bad_c = 1'b1;
  end

  // hash byte stream, low byte of each word first
  assign hash_src = {63'd0, rec.full_upload, 31'd0, ftot, 32'd0, rec.lm_bytes,
                     32'd0, rec.tr_bytes, 32'd0, rec.frame_index};
  assign hbyte = hash_src[byte_cnt*8 +: 8];
  assign hx = hash_work ^ {56'd0, hbyte};

  assign stat = '{bad: bad_c, hash_last: (byte_cnt == CntW'(HashBytes - 1))};

  // fold one byte per step; the prime is 2^40 + 0x1B3, so shift and add
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_cnt <= '0;
      hash_work <= hash_reg;
    end else if (cmd.hash_step) begin
      byte_cnt <= byte_cnt + 1'b1;
      hash_work <= hx + (hx << 1) + (hx << 4) + (hx << 5) + (hx << 7) + (hx << 8) +
                   (hx << 40);
    end
  end

  // remember verdict from CHECK
  always_ff @(posedge clk) begin
    if (cmd.load) bad <= 1'b0;
    else if (!cmd.hash_step && !cmd.commit) bad <= bad_c;
  end

  // commit accepted record, then publish
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0; first_transient <= '0; bounded_size <= '0;
      t_min <= '0; t_max <= '0; f_min <= '0; f_max <= '0;
      tot_t <= '0; tot_l <= '0; tot_u <= '0;
      hash_reg <= FnvBasis; variation <= '0; full_count <= '0; mode_reg <= 1'b0;
    end else if (cmd.commit && !bad) begin
      if (frame_count == 32'd0) begin
        first_transient <= rec.tr_bytes;
        t_min <= rec.tr_bytes;
        t_max <= rec.tr_bytes;
      end else begin
        if (rec.tr_bytes < t_min) t_min <= rec.tr_bytes;
        if (rec.tr_bytes > t_max) t_max <= rec.tr_bytes;
        if (rec.tr_bytes != first_transient) variation <= variation + 1'b1;
      end
      if (!rec.full_upload) bounded_size <= rec.lm_bytes;
      tot_t <= nt[47:0]; tot_l <= nl[47:0]; tot_u <= nu[47:0];
      if (frame_count == 32'd0 || ftot < f_min) f_min <= ftot;
      if (ftot > f_max) f_max <= ftot;
      if (rec.full_upload) full_count <= full_count + 1'b1;
      hash_reg <= hash_work;
      frame_count <= frame_count + 1'b1;
      mode_reg <= rec.variable_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_q <= bad;
      ftot_q <= bad ? 33'd0 : ftot;
    end
  end

  always_comb begin
    out_word.status = status_q;
    out_word.frame_bytes = ftot_q;
    out_word.transient_sum = tot_t;
    out_word.lightmap_sum = tot_l;
    out_word.upload_sum = tot_u;
    out_word.chain_hash = hash_reg;
    out_word.transient_low = t_min;
    out_word.transient_high = t_max;
    out_word.variation_count = variation;
    out_word.frame_bytes_low = f_min;
    out_word.frame_bytes_high = f_max;
    out_word.frames_done = frame_count;
  end
endmodule
